[src/pfba_pkg.sv]
package pfba_pkg;

    // Bitmap geometry
    localparam int BITMAP_WORDS = 1024;
    localparam int ADDR_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int FRAME_W      = 15;
    localparam int BIT_W        = 5;
    localparam int WORD_W       = FRAME_W - BIT_W;
    localparam int DATA_W       = 32;
    localparam int CFG_W        = 11;

    // A 15-bit frame number names at most 1024 words
    localparam int ADDRESSABLE_WORDS = 1 << WORD_W;
    localparam int EFF_CAP = (BITMAP_WORDS < ADDRESSABLE_WORDS) ? BITMAP_WORDS
                                                                : ADDRESSABLE_WORDS;

    localparam logic [DATA_W-1:0] ALL_TAKEN = '1;
    localparam logic [DATA_W-1:0] TOP_MASK  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CFG_W-1:0]  WORDS_RESET = CFG_W'(1024);

    // Register map
    localparam logic REG_WORDS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        OP_TAKE = 2'd0,
        OP_FREE = 2'd1,
        OP_FIND = 2'd2,
        OP_RSVD = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE_FREE = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_SCAN,
        S_DONE
    } t_state;

    // Lowest free frame offset in a word; bit 31 is offset zero
    function automatic logic [BIT_W-1:0] first_free(input logic [DATA_W-1:0] v);
        logic [BIT_W-1:0] k;
        k = '0;
        for (int i = DATA_W - 1; i >= 0; i--) begin
            if (!v[DATA_W-1-i]) begin
                k = BIT_W'(i);
            end
        end
        return k;
    endfunction

endpackage

[src/pfba_ram.sv]
module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/page_frame_bitmap_allocator.sv]
// Channel   | Dir | Handshake           | Payload
// ----------+-----+---------------------+----------------------------------
// request   | in  | i_valid / o_ready   | i_operation, i_frame_index
// result    | out | o_valid / i_ready   | o_found_frame, o_status
// config    | in  | APB psel/penable    | paddr, pwdata, prdata (words_in_use)
//
// Mark taken/free: accept and read word, write back, then the result stage.
// Find: accept, a scan of N words, then the result stage; N = words scanned
//   up to and including the first word with a free frame, or every word in
//   use when none is free; one bitmap word per cycle through the RAM read port.
// Out-of-range marks, unused opcodes, finds over zero words in use: accept, then result stage.
// Reset: a clearing pass over all BITMAP_WORDS words (1024) writes every word free;
//   no request is taken meanwhile, config writes are.
// A full output register holds the engine in its result stage until taken.
module page_frame_bitmap_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [pfba_pkg::FRAME_W-1:0]  i_frame_index,
    // result
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pfba_pkg::FRAME_W-1:0]  o_found_frame,
    output logic [1:0]                    o_status,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // control
    pfba_pkg::t_state                  r_state, n_state;
    pfba_pkg::t_op                     r_op, n_op;
    logic [pfba_pkg::ADDR_W-1:0]       r_clr_addr, n_clr_addr;
    logic [pfba_pkg::WORD_W-1:0]       r_word, n_word;     // word under test / to mark
    logic [pfba_pkg::BIT_W-1:0]        r_bit, n_bit;
    logic                              r_out_valid, n_out_valid;
    logic [pfba_pkg::CFG_W-1:0]        r_words_in_use;

    // payload
    logic [pfba_pkg::FRAME_W-1:0]      r_res_found, n_res_found;
    logic [1:0]                        r_res_status, n_res_status;
    logic [pfba_pkg::FRAME_W-1:0]      r_out_found, n_out_found;
    logic [1:0]                        r_out_status, n_out_status;

    // bitmap RAM
    logic                              ram_we;
    logic [pfba_pkg::ADDR_W-1:0]       ram_waddr;
    logic [pfba_pkg::DATA_W-1:0]       ram_wdata;
    logic [pfba_pkg::ADDR_W-1:0]       ram_raddr;
    logic [pfba_pkg::DATA_W-1:0]       ram_rdata;

    logic [pfba_pkg::CFG_W-1:0]        eff_words;
    logic [pfba_pkg::DATA_W-1:0]       bit_mask;
    logic [pfba_pkg::WORD_W-1:0]       word_next;
    logic                              cfg_write;

    // ------------------------------------------------------------------
    // Config port: single register, no wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == pfba_pkg::REG_WORDS_IN_USE)
                       ? {{(32-pfba_pkg::CFG_W){1'b0}}, r_words_in_use} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_in_use <= pfba_pkg::WORDS_RESET;
        end else if (cfg_write && paddr[2] == pfba_pkg::REG_WORDS_IN_USE) begin
            r_words_in_use <= pwdata[pfba_pkg::CFG_W-1:0];
        end
    end

    // Word count clipped to the RAM depth and to what a frame number can name
    assign eff_words = (r_words_in_use > pfba_pkg::CFG_W'(pfba_pkg::EFF_CAP))
                       ? pfba_pkg::CFG_W'(pfba_pkg::EFF_CAP) : r_words_in_use;

    assign bit_mask  = pfba_pkg::TOP_MASK >> r_bit;
    assign word_next = r_word + pfba_pkg::WORD_W'(1);

    // ------------------------------------------------------------------
    // Bitmap storage
    // ------------------------------------------------------------------
    pfba_ram #(
        .WIDTH (pfba_pkg::DATA_W),
        .DEPTH (pfba_pkg::BITMAP_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer. Only one request is in flight, so the write-back of a mark
    // always lands before the next read: no forwarding path is needed.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfba_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_clr_addr   = r_clr_addr;
        n_word       = r_word;
        n_bit        = r_bit;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !i_ready;
        o_ready      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = pfba_pkg::ADDR_W'(r_word);
        ram_wdata    = '0;
        ram_raddr    = pfba_pkg::ADDR_W'(r_word);

        case (r_state)
            pfba_pkg::S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + pfba_pkg::ADDR_W'(1);
                if (r_clr_addr == pfba_pkg::ADDR_W'(pfba_pkg::BITMAP_WORDS - 1)) begin
                    n_state = pfba_pkg::S_IDLE;
                end
            end

            pfba_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op         = pfba_pkg::t_op'(i_operation);
                    n_word       = i_frame_index[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W];
                    n_bit        = i_frame_index[pfba_pkg::BIT_W-1:0];
                    n_res_found  = '0;
                    n_res_status = pfba_pkg::ST_OK;
                    case (pfba_pkg::t_op'(i_operation))
                        pfba_pkg::OP_TAKE, pfba_pkg::OP_FREE: begin
                            if ({1'b0, i_frame_index[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W]}
                                >= eff_words) begin
                                n_res_status = pfba_pkg::ST_RANGE;
                                n_state      = pfba_pkg::S_DONE;
                            end else begin
                                ram_raddr = pfba_pkg::ADDR_W'(
                                    i_frame_index[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W]);
                                n_state   = pfba_pkg::S_MARK;
                            end
                        end
                        pfba_pkg::OP_FIND: begin
                            n_word = '0;
                            if (eff_words == '0) begin
                                n_res_status = pfba_pkg::ST_NONE_FREE;
                                n_state      = pfba_pkg::S_DONE;
                            end else begin
                                ram_raddr = '0;
                                n_state   = pfba_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            n_state = pfba_pkg::S_DONE;
                        end
                    endcase
                end
            end

            pfba_pkg::S_MARK: begin
                // read data for r_word is here; modify and write back
                ram_we    = 1'b1;
                ram_wdata = (r_op == pfba_pkg::OP_TAKE) ? (ram_rdata | bit_mask)
                                                        : (ram_rdata & ~bit_mask);
                n_state   = pfba_pkg::S_DONE;
            end

            pfba_pkg::S_SCAN: begin
                // one word per cycle; the next read goes out speculatively
                ram_raddr = pfba_pkg::ADDR_W'(word_next);
                if (ram_rdata != pfba_pkg::ALL_TAKEN) begin
                    n_res_found  = {r_word, pfba_pkg::first_free(ram_rdata)};
                    n_res_status = pfba_pkg::ST_OK;
                    n_state      = pfba_pkg::S_DONE;
                end else if (({1'b0, r_word} + pfba_pkg::CFG_W'(1)) == eff_words) begin
                    n_res_found  = '0;
                    n_res_status = pfba_pkg::ST_NONE_FREE;
                    n_state      = pfba_pkg::S_DONE;
                end else begin
                    n_word = word_next;
                end
            end

            pfba_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_res_found;
                    n_out_status = r_res_status;
                    n_state      = pfba_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pfba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_found_frame = r_out_found;
    assign o_status      = r_out_status;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_req_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfba_pkg::S_CLEAR) |-> !o_ready)
        else $error("request taken during clearing pass");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request taken while one is in flight");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfba_pkg::S_SCAN) |-> ({1'b0, r_word} < eff_words))
        else $error("scan ran past the words in use");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == pfba_pkg::ST_OK || o_status == pfba_pkg::ST_NONE_FREE
                     || o_status == pfba_pkg::ST_RANGE))
        else $error("illegal status code");

    a_error_zero_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != pfba_pkg::ST_OK) |-> (o_found_frame == '0))
        else $error("nonzero frame on error result");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_TARGET    = 1750;
    localparam int QUIET_TAIL     = 200;   // last requests run with no idling
    localparam int HOLD_OFF_LEN   = 300;   // long receiver stall, in cycles
    localparam int WATCHDOG_LIMIT = 5000;  // > clearing pass and any full scan
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 20;

    // One answer per request: found frame plus status
    typedef struct packed {
        logic [pfba_pkg::FRAME_W-1:0] frame;
        logic [1:0]                   status;
    } t_frame_answer;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // Directed row: a request (op, frame index) or a words_in_use write (arg).
    // When 'typed' is set the answer is given here instead of by the predictor.
    typedef struct {
        t_row_kind     kind;
        pfba_pkg::t_op op;
        int            arg;
        bit            typed;
        int            frame;
        logic [1:0]    status;
    } t_dir_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [1:0]                   i_operation = pfba_pkg::OP_TAKE;
    logic [pfba_pkg::FRAME_W-1:0] i_frame_index = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [pfba_pkg::FRAME_W-1:0] o_found_frame;
    logic [1:0]                   o_status;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [2:0]                   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    page_frame_bitmap_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_frame_index (i_frame_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found_frame (o_found_frame),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the frame bitmap and the register
    // ------------------------------------------------------------------
    logic [pfba_pkg::DATA_W-1:0] frame_map [pfba_pkg::BITMAP_WORDS];
    logic [pfba_pkg::CFG_W-1:0]  words_cfg = pfba_pkg::WORDS_RESET;

    t_frame_answer frame_answers_due[$];

    int  mismatches      = 0;
    int  requests_sent   = 0;
    int  answers_checked = 0;
    int  finds_sent      = 0;
    int  none_free_seen  = 0;
    int  range_seen      = 0;
    int  cfg_writes      = 0;
    int  send_gap_pct    = 25;
    bit  no_idle         = 1'b0;
    int  hold_off_asked  = 0;
    int  stall_cycles    = 0;

    // words_in_use is clamped to what the bitmap holds and a frame number names
    function automatic int eff_words();
        return (int'(words_cfg) > pfba_pkg::EFF_CAP) ? pfba_pkg::EFF_CAP : int'(words_cfg);
    endfunction

    // Applies one request to the shadow bitmap and returns its answer
    function automatic t_frame_answer predict_frame_op(
        input pfba_pkg::t_op op, input logic [pfba_pkg::FRAME_W-1:0] idx);
        t_frame_answer ans;
        int            eff;
        bit            hit;
        eff        = eff_words();
        ans.frame  = '0;
        ans.status = pfba_pkg::ST_OK;
        hit        = 1'b0;
        case (op)
            pfba_pkg::OP_TAKE, pfba_pkg::OP_FREE: begin
                if (int'(idx) >= eff * 32) begin
                    ans.status = pfba_pkg::ST_RANGE;
                end else begin
                    // bit 31 is the lowest frame of the word
                    frame_map[idx[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W]]
                             [31 - int'(idx[pfba_pkg::BIT_W-1:0])] =
                        (op == pfba_pkg::OP_TAKE);
                end
            end
            pfba_pkg::OP_FIND: begin
                for (int w = 0; w < eff && !hit; w++) begin
                    if (frame_map[w] != pfba_pkg::ALL_TAKEN) begin
                        for (int k = 0; k < 32 && !hit; k++) begin
                            if (!frame_map[w][31 - k]) begin
                                ans.frame = pfba_pkg::FRAME_W'(w * 32 + k);
                                hit       = 1'b1;
                            end
                        end
                    end
                end
                if (!hit) begin
                    ans.status = pfba_pkg::ST_NONE_FREE;
                end
            end
            default: ;  // unused code: no change, ok
        endcase
        return ans;
    endfunction

    function automatic logic [pfba_pkg::FRAME_W-1:0] frame_in_use();
        int eff;
        eff = eff_words();
        return (eff == 0) ? pfba_pkg::FRAME_W'($urandom)
                          : pfba_pkg::FRAME_W'($urandom_range(0, eff * 32 - 1));
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request; the shadow bitmap is updated once it is taken.
    // Valid stays high afterwards so back-to-back requests need no re-raise.
    task automatic send_request(input pfba_pkg::t_op op,
                                input logic [pfba_pkg::FRAME_W-1:0] idx,
                                input bit use_typed, input t_frame_answer typed_ans,
                                output t_frame_answer ans);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < send_gap_pct) begin
            gap = $urandom_range(1, 12);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_frame_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        ans = predict_frame_op(op, idx);
        frame_answers_due.push_back(use_typed ? typed_ans : ans);
        requests_sent++;
        if (op == pfba_pkg::OP_FIND) begin
            finds_sent++;
        end
    endtask

    task automatic issue(input pfba_pkg::t_op op, input logic [pfba_pkg::FRAME_W-1:0] idx,
                         output t_frame_answer ans);
        send_request(op, idx, 1'b0, '0, ans);
    endtask

    // Stop offering and wait for every outstanding answer, then let the
    // engine go quiet before touching the register
    task automatic settle_block();
        i_valid <= 1'b0;
        while (frame_answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_words_in_use(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * pfba_pkg::REG_WORDS_IN_USE);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        words_cfg = value[pfba_pkg::CFG_W-1:0];
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Directed rows: reset state, extremes of the index, every opcode,
    // zero and clamped word counts, redundant marks, out-of-range marks
    // ------------------------------------------------------------------
    t_dir_row directed_rows [25] = '{
        '{ROW_REQ, pfba_pkg::OP_FIND,     0, 1'b1, 0, pfba_pkg::ST_OK}, // fresh bitmap
        '{ROW_REQ, pfba_pkg::OP_TAKE,     0, 1'b1, 0, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_FIND,     0, 1'b1, 1, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_TAKE, 32767, 1'b1, 0, pfba_pkg::ST_OK}, // top frame
        '{ROW_REQ, pfba_pkg::OP_TAKE, 32767, 1'b1, 0, pfba_pkg::ST_OK}, // already taken
        '{ROW_REQ, pfba_pkg::OP_FREE, 32767, 1'b1, 0, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_FREE,   100, 1'b1, 0, pfba_pkg::ST_OK}, // already free
        '{ROW_REQ, pfba_pkg::OP_RSVD, 32767, 1'b1, 0, pfba_pkg::ST_OK}, // unused code
        '{ROW_REQ, pfba_pkg::OP_FREE,     0, 1'b1, 0, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_FIND, 12345, 1'b1, 0, pfba_pkg::ST_OK}, // index ignored
        '{ROW_CFG, pfba_pkg::OP_TAKE,     1, 1'b0, 0, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_TAKE,    32, 1'b1, 0, pfba_pkg::ST_RANGE}, // past one word
        '{ROW_REQ, pfba_pkg::OP_FREE, 32767, 1'b1, 0, pfba_pkg::ST_RANGE},
        '{ROW_REQ, pfba_pkg::OP_TAKE,    31, 1'b1, 0, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_FIND,     0, 1'b0, 0, pfba_pkg::ST_OK},
        '{ROW_CFG, pfba_pkg::OP_TAKE,     0, 1'b0, 0, pfba_pkg::ST_OK}, // no frames in use
        '{ROW_REQ, pfba_pkg::OP_FIND,     0, 1'b1, 0, pfba_pkg::ST_NONE_FREE},
        '{ROW_REQ, pfba_pkg::OP_TAKE,     0, 1'b1, 0, pfba_pkg::ST_RANGE},
        '{ROW_REQ, pfba_pkg::OP_RSVD,     0, 1'b1, 0, pfba_pkg::ST_OK},
        '{ROW_CFG, pfba_pkg::OP_TAKE,  2047, 1'b0, 0, pfba_pkg::ST_OK}, // clamps to 1024
        '{ROW_REQ, pfba_pkg::OP_TAKE, 32767, 1'b1, 0, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_FIND,     0, 1'b0, 0, pfba_pkg::ST_OK},
        '{ROW_CFG, pfba_pkg::OP_TAKE,  1024, 1'b0, 0, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_FREE, 32767, 1'b0, 0, pfba_pkg::ST_OK},
        '{ROW_REQ, pfba_pkg::OP_FREE,    31, 1'b0, 0, pfba_pkg::ST_OK}
    };

    initial begin
        t_frame_answer ans;
        t_frame_answer typed_ans;
        int            phase_idx;
        int            phase_end;
        int            eff;
        int            cfg_value;
        int            run_len;
        int            fill_words;
        int            word_base;
        int            j;
        int            tmp;
        int            order [32];
        bit            paused_once;

        phase_idx   = 0;
        paused_once = 1'b0;
        for (int w = 0; w < pfba_pkg::BITMAP_WORDS; w++) begin
            frame_map[w] = '0;
        end

        // Synchronous reset, once; the block then runs its clearing pass
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle_block();
                write_words_in_use(32'(directed_rows[r].arg));
            end else begin
                typed_ans.frame  = pfba_pkg::FRAME_W'(directed_rows[r].frame);
                typed_ans.status = directed_rows[r].status;
                send_request(directed_rows[r].op, pfba_pkg::FRAME_W'(directed_rows[r].arg),
                             directed_rows[r].typed, typed_ans, ans);
            end
        end

        // Random phases: each picks a word count, then mixes allocator-like
        // runs (find then take), word fills, frees and noise
        while (requests_sent < ITEM_TARGET) begin
            phase_idx++;
            settle_block();
            case ($urandom_range(0, 19))
                0:       cfg_value = 0;
                1:       cfg_value = 1024;
                2:       cfg_value = 2047;
                3:       cfg_value = $urandom_range(5, 64);
                4:       cfg_value = $urandom_range(0, 1) ? 1023 : 1025;
                5:       cfg_value = $urandom_range(0, 2047);
                default: cfg_value = $urandom_range(1, 4);
            endcase
            write_words_in_use(32'(cfg_value));
            eff          = eff_words();
            no_idle      = (requests_sent > ITEM_TARGET - QUIET_TAIL);
            send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
            // receiver sits out a long stretch while requests keep coming
            if (phase_idx == 4) begin
                hold_off_asked++;
            end
            phase_end = requests_sent + $urandom_range(40, 90);
            while (requests_sent < phase_end) begin
                // sender pauses mid-phase until every answer is back
                if (phase_idx == 7 && !paused_once && phase_end - requests_sent < 30) begin
                    settle_block();
                    paused_once = 1'b1;
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        run_len = $urandom_range(1, 8);
                        repeat (run_len) begin
                            issue(pfba_pkg::OP_FIND, pfba_pkg::FRAME_W'($urandom), ans);
                            if (ans.status == pfba_pkg::ST_OK) begin
                                issue(pfba_pkg::OP_TAKE, ans.frame, ans);
                            end
                        end
                    end
                    3: begin
                        // fill words in shuffled order, so a find comes up empty
                        // when every word in use is full
                        if (eff > 0 && eff <= 4) begin
                            fill_words = (eff <= 2) ? eff : 1;
                            for (int w = 0; w < fill_words; w++) begin
                                word_base = (eff <= 2) ? w : $urandom_range(0, eff - 1);
                                for (int i = 0; i < 32; i++) begin
                                    order[i] = i;
                                end
                                for (int i = 31; i > 0; i--) begin
                                    j        = $urandom_range(0, i);
                                    tmp      = order[i];
                                    order[i] = order[j];
                                    order[j] = tmp;
                                end
                                for (int i = 0; i < 32; i++) begin
                                    issue(pfba_pkg::OP_TAKE,
                                          pfba_pkg::FRAME_W'(word_base * 32 + order[i]), ans);
                                end
                            end
                            issue(pfba_pkg::OP_FIND, pfba_pkg::FRAME_W'($urandom), ans);
                            issue(pfba_pkg::OP_FREE, frame_in_use(), ans);
                            issue(pfba_pkg::OP_FIND, pfba_pkg::FRAME_W'($urandom), ans);
                        end else begin
                            issue(pfba_pkg::OP_TAKE, frame_in_use(), ans);
                        end
                    end
                    4: begin
                        run_len = $urandom_range(1, 6);
                        repeat (run_len) begin
                            issue(pfba_pkg::OP_FREE, frame_in_use(), ans);
                        end
                    end
                    5: begin
                        issue(pfba_pkg::t_op'($urandom_range(0, 3)),
                              pfba_pkg::FRAME_W'($urandom), ans);
                    end
                    6: begin
                        if (eff < pfba_pkg::EFF_CAP) begin
                            issue($urandom_range(0, 1) ? pfba_pkg::OP_TAKE : pfba_pkg::OP_FREE,
                                  pfba_pkg::FRAME_W'($urandom_range(eff * 32, 32767)), ans);
                        end else begin
                            issue(pfba_pkg::OP_RSVD, pfba_pkg::FRAME_W'($urandom), ans);
                        end
                    end
                    default: begin
                        issue(pfba_pkg::t_op'($urandom_range(0, 2)), frame_in_use(), ans);
                    end
                endcase
            end
        end

        settle_block();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Run covered %0d requests (%0d finds) over %0d word-count writes,",
                 requests_sent, finds_sent, cfg_writes);
        $display("with %0d answers checked: %0d empty finds, %0d out-of-range marks.",
                 answers_checked, none_free_seen, range_seen);
        if (mismatches == 0) begin
            $display("PASS page_frame_bitmap_allocator");
        end else begin
            $display("FAIL page_frame_bitmap_allocator");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, one long hold-off on request,
    // and steady ready in the quiet tail
    // ------------------------------------------------------------------
    initial begin
        int hold_off_given;
        hold_off_given = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_given != hold_off_asked) begin
                hold_off_given = hold_off_asked;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Answer checker: oldest expectation against each accepted answer
    always @(posedge i_clk) begin
        t_frame_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_answers_due.size() == 0) begin
                mismatches++;
                $display("%0t: answer with none due, got frame %0d status %0d",
                         $time, o_found_frame, o_status);
            end else begin
                want = frame_answers_due.pop_front();
                answers_checked++;
                if (o_found_frame !== want.frame) begin
                    mismatches++;
                    $display("%0t: found_frame mismatch, expected %0d, got %0d",
                             $time, want.frame, o_found_frame);
                end
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_status);
                end
                if (want.status == pfba_pkg::ST_NONE_FREE) begin
                    none_free_seen++;
                end
                if (want.status == pfba_pkg::ST_RANGE) begin
                    range_seen++;
                end
            end
        end
    end

    // Watchdog: cycles with no request, answer or register write accepted
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no progress for %0d cycles, %0d answers still due",
                 $time, WATCHDOG_LIMIT, frame_answers_due.size());
        $display("FAIL page_frame_bitmap_allocator");
        $finish;
    end

endmodule

[sim.f]
src/pfba_pkg.sv
src/pfba_ram.sv
src/page_frame_bitmap_allocator.sv
sim/testbench.sv
